FILE: rtl/tpq_pkg.sv
// ----------------------------------------------------------------------------
// tpq_pkg
// Shared types and constants for the task priority queue.
// ----------------------------------------------------------------------------
package tpq_pkg;

    localparam int Depth = 32;
    localparam int SlotW = $clog2(Depth);
    localparam int CntW  = $clog2(Depth + 1);
    localparam int TallyW = 6;

    typedef enum logic [2:0] {
        OP_ENQ    = 3'd0,
        OP_DEQ    = 3'd1,
        OP_DEQFIT = 3'd2,
        OP_PEEK   = 3'd3,
        OP_REMOVE = 3'd4,
        OP_HAS    = 3'd5,
        OP_COUNT  = 3'd6,
        OP_CLEAR  = 3'd7
    } op_t;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NONE  = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [31:0] id;
        logic [2:0]  level;
        logic [7:0]  cpu;
        logic [47:0] mem;
        logic [47:0] gmem;
        logic [3:0]  gcnt;
        logic [47:0] disk;
    } task_t;

    localparam int TaskW = $bits(task_t);
    localparam int RowW  = TaskW + 32;

    typedef struct packed {
        logic [2:0]  operation;
        task_t       tsk;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        task_t       tsk;
        logic [5:0]  tally;
    } rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic             load;     // latch request
        logic             scan_clr; // reset scan state
        logic             scan_en;  // visit one slot
        logic             commit;   // apply result
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic             scan_last;
    } sts_t;

endpackage

FILE: rtl/tpq_if.sv
// ----------------------------------------------------------------------------
// tpq_if
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
interface tpq_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/tpq_ram.sv
// ----------------------------------------------------------------------------
// tpq_ram
// Generic single-port-write, single-read RAM with registered read.
// ----------------------------------------------------------------------------
module tpq_ram #(
    parameter int Width = 8,
    parameter int Depth = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: rtl/tpq_ctrl.sv
// ----------------------------------------------------------------------------
// tpq_ctrl
// Sequencer: accept, scan all slots, commit, hand result to output.
// ----------------------------------------------------------------------------
module tpq_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    output tpq_pkg::cmd_t  cmd,
    input  tpq_pkg::sts_t  sts
);
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_COMMIT,
        S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load     = 1'b1;
                    cmd.scan_clr = 1'b1;
                    state_next   = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_en = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                if (!out_valid_next)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule

FILE: rtl/tpq_dp.sv
// ----------------------------------------------------------------------------
// tpq_dp
// Slot RAM, valid bits, scan pipeline (RAM read issued ahead of the check), selection
// of best or fitting entry, id match, level count, and result register.
// ----------------------------------------------------------------------------
module tpq_dp (
    input  logic           clk,
    input  logic           rst_n,
    input  tpq_pkg::req_t  req,
    input  tpq_pkg::cmd_t  cmd,
    output tpq_pkg::sts_t  sts,
    output tpq_pkg::rsp_t  rsp
);
    localparam int SW = tpq_pkg::SlotW;
    localparam int CW = tpq_pkg::CntW;

    tpq_pkg::req_t          req_reg;
    logic [tpq_pkg::Depth-1:0] valid_reg, valid_next;
    logic [31:0]            arr_reg;
    logic [CW-1:0]          occ_reg;
    logic [CW:0]            scan_reg;     // read address counter, one extra bit
    logic                   chk_reg;      // rdata valid for slot chk_idx_reg
    logic [SW-1:0]          chk_idx_reg;
    logic                   found_reg;
    logic [SW-1:0]          best_reg;
    logic [31:0]            best_age_reg;
    tpq_pkg::task_t         best_task_reg;
    logic                   free_found_reg;
    logic [SW-1:0]          free_reg;
    logic [CW-1:0]          cnt_reg;
    logic [tpq_pkg::Depth-1:0] hit_reg;
    tpq_pkg::rsp_t          rsp_reg;

    logic [tpq_pkg::RowW-1:0] rdata;
    logic [SW-1:0]          raddr;
    tpq_pkg::task_t         rtask;
    logic [31:0]            rarr;
    logic [31:0]            age;
    logic                   live, fit, better, wr;
    logic [2:0]             op;

    assign op    = req_reg.operation;
    assign rtask = rdata[tpq_pkg::RowW-1:32];
    assign rarr  = rdata[31:0];
    assign age   = arr_reg - rarr;
    assign live  = chk_reg && valid_reg[chk_idx_reg];
    assign fit   = (rtask.cpu  <= req_reg.tsk.cpu)  && (rtask.mem  <= req_reg.tsk.mem)
                && (rtask.gmem <= req_reg.tsk.gmem) && (rtask.gcnt <= req_reg.tsk.gcnt)
                && (rtask.disk <= req_reg.tsk.disk);
    assign better = !found_reg || (rtask.level < best_task_reg.level)
                 || ((rtask.level == best_task_reg.level) && (age > best_age_reg));
    assign wr = cmd.commit && (op == tpq_pkg::OP_ENQ) && free_found_reg;

    // slot 0 is read in the load cycle so it is ready for the first check
    assign raddr = cmd.scan_clr ? SW'(0) : scan_reg[SW-1:0];

    assign sts.scan_last = chk_reg && (chk_idx_reg == SW'(tpq_pkg::Depth - 1));

    tpq_ram #(.Width(tpq_pkg::RowW), .Depth(tpq_pkg::Depth)) u_ram (
        .clk   (clk),
        .we    (wr),
        .waddr (free_reg),
        .wdata ({req_reg.tsk, arr_reg}),
        .raddr (raddr),
        .rdata (rdata)
    );

    function automatic tpq_pkg::rsp_t rsp_next();
        tpq_pkg::rsp_t r;
        logic [CW-1:0] n;
        r = '0;
        n = occ_reg;
        case (op)
            tpq_pkg::OP_ENQ:
            begin
                if (free_found_reg)
                begin
                    n = occ_reg + 1'b1;
                end
                else
                begin
                    r.status = tpq_pkg::ST_FULL;
                end
            end
            tpq_pkg::OP_DEQ, tpq_pkg::OP_DEQFIT, tpq_pkg::OP_PEEK:
            begin
                if (found_reg)
                begin
                    r.tsk = best_task_reg;
                    if (op != tpq_pkg::OP_PEEK)
                    begin
                        n = occ_reg - 1'b1;
                    end
                end
                else
                begin
                    r.status = tpq_pkg::ST_NONE;
                end
            end
            tpq_pkg::OP_REMOVE:
            begin
                n = occ_reg - CW'($countones(hit_reg));
                r.status = (|hit_reg) ? tpq_pkg::ST_OK : tpq_pkg::ST_NONE;
            end
            tpq_pkg::OP_HAS:
            begin
                r.status = (|hit_reg) ? tpq_pkg::ST_OK : tpq_pkg::ST_NONE;
            end
            tpq_pkg::OP_COUNT:
            begin
                n = cnt_reg;
            end
            default:
            begin
                n = '0;
            end
        endcase
        r.tally = (n > CW'(63)) ? 6'd63 : n[5:0];
        return r;
    endfunction

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req;
        end
        if (cmd.scan_clr)
        begin
            found_reg <= 1'b0;
            free_found_reg <= 1'b0;
            cnt_reg <= '0;
            hit_reg <= '0;
            best_age_reg <= '0;
            best_reg <= '0;
            free_reg <= '0;
            best_task_reg <= '0;
        end
        else if (cmd.scan_en && chk_reg)
        begin
            if (!valid_reg[chk_idx_reg] && !free_found_reg)
            begin
                free_found_reg <= 1'b1;
                free_reg <= chk_idx_reg;
            end
            if (live && (op != tpq_pkg::OP_DEQFIT || fit) && better)
            begin
                found_reg <= 1'b1;
                best_reg <= chk_idx_reg;
                best_age_reg <= age;
                best_task_reg <= rtask;
            end
            if (live && rtask.level == req_reg.tsk.level)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            hit_reg[chk_idx_reg] <= live && (rtask.id == req_reg.tsk.id);
        end
        if (cmd.commit)
        begin
            rsp_reg <= rsp_next();
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.commit)
        begin
            case (op)
                tpq_pkg::OP_ENQ:
                begin
                    if (free_found_reg)
                    begin
                        valid_next[free_reg] = 1'b1;
                    end
                end
                tpq_pkg::OP_DEQ, tpq_pkg::OP_DEQFIT:
                begin
                    if (found_reg)
                    begin
                        valid_next[best_reg] = 1'b0;
                    end
                end
                tpq_pkg::OP_REMOVE:
                begin
                    valid_next = valid_reg & ~hit_reg;
                end
                tpq_pkg::OP_CLEAR:
                begin
                    valid_next = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            arr_reg     <= '0;
            occ_reg     <= '0;
            scan_reg    <= '0;
            chk_reg     <= 1'b0;
            chk_idx_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (cmd.commit)
            begin
                occ_reg <= CW'($countones(valid_next));
                if (wr)
                begin
                    arr_reg <= arr_reg + 32'd1;
                end
            end
            if (cmd.scan_clr)
            begin
                scan_reg    <= (CW+1)'(1);
                chk_reg     <= 1'b1;
                chk_idx_reg <= '0;
            end
            else if (cmd.scan_en)
            begin
                scan_reg    <= scan_reg + 1'b1;
                chk_reg     <= (scan_reg < (CW+1)'(tpq_pkg::Depth));
                chk_idx_reg <= scan_reg[SW-1:0];
            end
        end
    end

    assign rsp = rsp_reg;
endmodule

FILE: rtl/task_priority_queue_fit_dequeue_unit.sv
// ----------------------------------------------------------------------------
// task_priority_queue_fit_dequeue_unit
// Bounded 32-entry task queue with lowest-level, oldest-first selection.
// ----------------------------------------------------------------------------
// A request is latched at its transfer. The scan then streams all 32 slots
// out of the slot RAM (one read port, one slot per cycle) through the
// selection, match and count logic, and the commit step then updates the
// valid bits and the result register that drives the output. Only one
// operation is in flight; a new request is accepted in the cycle after
// commit, even while the result waits on the output. A stalled output
// holds the next commit until the pending result transfers.
module task_priority_queue_fit_dequeue_unit (
    input  logic clk,
    input  logic rst_n,
    tpq_if.sink   in_ch,
    tpq_if.source out_ch
);
    tpq_pkg::cmd_t cmd;
    tpq_pkg::sts_t sts;

    tpq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    tpq_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (in_ch.data),
        .cmd   (cmd),
        .sts   (sts),
        .rsp   (out_ch.data)
    );

    a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.load && cmd.commit))
        else $error("load and commit together");

    a_load_on_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (in_ch.valid && in_ch.ready))
        else $error("load without transfer");

    a_out_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_ch.valid)
        else $error("commit did not raise output");
endmodule
